// File: rtl/core/lsb_stego_payload_extractor_top_macros.svh
// assertion macros shared by the extractor checker
`ifndef LSB_STEGO_PAYLOAD_EXTRACTOR_TOP_MACROS_SVH
`define LSB_STEGO_PAYLOAD_EXTRACTOR_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define LSBSE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lsbse check failed");

// next-cycle implication, disabled in reset
`define LSBSE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lsbse check failed");

`endif

// File: rtl/core/lsbse_pkg.sv
// types and constants of the lsb stego payload extractor
`timescale 1ns / 1ps

package lsbse_pkg;

   localparam int BITS_PER_CHAR = 8;
   localparam logic [3:0] MAX_MAGIC_CHARS = 4'd8;
   localparam logic [3:0] MAX_EXT_CHARS   = 4'd8;
   localparam logic [3:0] MAX_SIZE_CHARS  = 4'd10;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_OFFSET = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAGIC_WORD   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAGIC_LENGTH = 2'd2;

   localparam logic [23:0] PIXEL_OFFSET_RESET = 24'd54;
   localparam logic [63:0] MAGIC_WORD_RESET   = 64'd0;
   localparam logic [3:0]  MAGIC_LENGTH_RESET = 4'd2;

   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;

   localparam logic [30:0] SIZE_MAX = 31'h7FFF_FFFF;

   typedef enum logic [2:0] {
      PH_SKIP,
      PH_MAGIC,
      PH_EXT,
      PH_SIZE,
      PH_PAYLOAD,
      PH_IDLE
   } phase_type;

   typedef enum logic [2:0] {
      KIND_EXT_CHAR,
      KIND_EXT_END,
      KIND_PAYLOAD,
      KIND_EMPTY_DONE,
      KIND_NO_MAGIC,
      KIND_TOO_LONG
   } out_kind_type;

   typedef struct packed {
      logic [7:0] image_byte;
      logic       start_of_file;
   } req_type;

   typedef struct packed {
      out_kind_type out_kind;
      logic [7:0]   out_char;
      logic         out_last;
   } rsp_type;

endpackage

// File: rtl/core/lsb_stego_payload_extractor_top.sv
// lsb stego payload extractor: header skip, bit packing and field decoding
// latency: a result is valid on the cycle after its request is accepted
// throughput: one request per cycle; the state update and result register share one cycle
// a request is taken whenever the result register is empty or being drained
// reset (synchronous) restores the registers to offset 54, magic 0, length 2
// and returns the decoder to header skip; no clearing pass is needed
`timescale 1ns / 1ps

module lsb_stego_payload_extractor_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  lsbse_pkg::req_type                    req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output lsbse_pkg::rsp_type                    rsp_data,
   input  logic                                  csr_write_en,
   input  logic [lsbse_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lsbse_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import lsbse_pkg::*;

   // configuration
   logic [23:0] pixel_offset_ff;
   logic [63:0] magic_word_ff;
   logic [3:0]  magic_length_ff;

   // decoder state
   phase_type   phase_ff, phase_in;
   logic [23:0] pos_ff, pos_in;
   logic [2:0]  bit_ff, bit_in;
   logic [7:0]  acc_ff, acc_in;
   logic [3:0]  fc_ff, fc_in;
   logic [30:0] size_ff, size_in;
   logic        neg_ff, neg_in;
   logic        stop_ff, stop_in;
   logic [30:0] rem_ff, rem_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        accept;
   logic        sof;
   phase_type   cur_phase;
   logic [23:0] cur_pos;
   logic [2:0]  cur_bit;
   logic [7:0]  cur_acc;
   logic [3:0]  cur_fc;
   logic [30:0] cur_size;
   logic        cur_neg;
   logic        cur_stop;
   logic [30:0] cur_rem;

   logic [3:0]  mlen;
   logic [7:0]  expect_char;
   logic [7:0]  acc_ins;
   logic [7:0]  chr;
   logic [7:0]  chr_off;
   logic [3:0]  digit;
   logic        is_digit;
   logic [34:0] size_wide;
   logic [30:0] size_sat;
   logic [3:0]  fc_inc;
   logic [30:0] rem_dec;
   logic        emit;
   rsp_type     result;

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // start of file clears the decoder before the byte is used
   assign sof       = req_data.start_of_file;
   assign cur_phase = sof ? PH_SKIP : phase_ff;
   assign cur_pos   = sof ? '0 : pos_ff;
   assign cur_bit   = sof ? '0 : bit_ff;
   assign cur_acc   = sof ? '0 : acc_ff;
   assign cur_fc    = sof ? '0 : fc_ff;
   assign cur_size  = sof ? '0 : size_ff;
   assign cur_neg   = sof ? 1'b0 : neg_ff;
   assign cur_stop  = sof ? 1'b0 : stop_ff;
   assign cur_rem   = sof ? '0 : rem_ff;

   assign mlen = (magic_length_ff == 4'd0) ? 4'd1 :
                 (magic_length_ff > MAX_MAGIC_CHARS) ? MAX_MAGIC_CHARS : magic_length_ff;
   assign expect_char = magic_word_ff[{cur_fc[2:0], 3'b000} +: 8];

   always_comb begin
      acc_ins = (cur_phase == PH_SKIP) ? 8'd0 : cur_acc;
      acc_ins[(cur_phase == PH_SKIP) ? 3'd0 : cur_bit] = req_data.image_byte[0];
   end

   assign chr       = acc_ins;
   assign chr_off   = chr - CHAR_ZERO;
   assign digit     = chr_off[3:0];
   assign is_digit  = (chr >= CHAR_ZERO) && (chr <= CHAR_NINE);
   assign size_wide = ({4'b0, cur_size} << 3) + ({4'b0, cur_size} << 1) + {31'b0, digit};
   assign size_sat  = (size_wide[34:31] != 4'd0) ? SIZE_MAX : size_wide[30:0];
   assign fc_inc    = cur_fc + 4'd1;
   assign rem_dec   = cur_rem - 31'd1;

   // next state and result
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      bit_in   = bit_ff;
      acc_in   = acc_ff;
      fc_in    = fc_ff;
      size_in  = size_ff;
      neg_in   = neg_ff;
      stop_in  = stop_ff;
      rem_in   = rem_ff;
      emit     = 1'b0;
      result   = '{out_kind: KIND_EXT_CHAR, out_char: 8'd0, out_last: 1'b0};

      if (accept) begin
         phase_in = cur_phase;
         pos_in   = cur_pos;
         bit_in   = cur_bit;
         acc_in   = cur_acc;
         fc_in    = cur_fc;
         size_in  = cur_size;
         neg_in   = cur_neg;
         stop_in  = cur_stop;
         rem_in   = cur_rem;

         if (cur_phase == PH_SKIP && cur_pos < pixel_offset_ff) begin
            pos_in = cur_pos + 24'd1;
         end else if (cur_phase != PH_IDLE) begin
            if (cur_phase == PH_SKIP) begin
               phase_in = PH_MAGIC;
               fc_in    = 4'd0;
            end
            bit_in = (cur_phase == PH_SKIP) ? 3'd1 : cur_bit + 3'd1;
            acc_in = acc_ins;

            if (cur_phase != PH_SKIP && cur_bit == 3'(BITS_PER_CHAR - 1)) begin
               bit_in = 3'd0;
               acc_in = 8'd0;
               unique case (cur_phase)
                  PH_MAGIC: begin
                     if (chr != expect_char) begin
                        phase_in = PH_IDLE;
                        emit     = 1'b1;
                        result   = '{out_kind: KIND_NO_MAGIC, out_char: 8'd0, out_last: 1'b1};
                     end else if (fc_inc >= mlen) begin
                        fc_in    = 4'd0;
                        phase_in = PH_EXT;
                     end else begin
                        fc_in = fc_inc;
                     end
                  end
                  PH_EXT: begin
                     emit = 1'b1;
                     if (chr == CHAR_STAR) begin
                        fc_in    = 4'd0;
                        phase_in = PH_SIZE;
                        result   = '{out_kind: KIND_EXT_END, out_char: 8'd0, out_last: 1'b0};
                     end else if (cur_fc >= MAX_EXT_CHARS) begin
                        phase_in = PH_IDLE;
                        result   = '{out_kind: KIND_TOO_LONG, out_char: 8'd0, out_last: 1'b1};
                     end else begin
                        fc_in  = fc_inc;
                        result = '{out_kind: KIND_EXT_CHAR, out_char: chr, out_last: 1'b0};
                     end
                  end
                  PH_SIZE: begin
                     if (chr == CHAR_STAR) begin
                        fc_in = 4'd0;
                        // a negative or zero size ends the file here
                        if (cur_neg || cur_size == 31'd0) begin
                           phase_in = PH_IDLE;
                           emit     = 1'b1;
                           result   = '{out_kind: KIND_EMPTY_DONE, out_char: 8'd0,
                                        out_last: 1'b1};
                        end else begin
                           rem_in   = cur_size;
                           phase_in = PH_PAYLOAD;
                        end
                     end else if (cur_fc >= MAX_SIZE_CHARS) begin
                        phase_in = PH_IDLE;
                        emit     = 1'b1;
                        result   = '{out_kind: KIND_TOO_LONG, out_char: 8'd0, out_last: 1'b1};
                     end else begin
                        fc_in = fc_inc;
                        if (cur_fc == 4'd0) begin
                           // first character may carry a sign
                           if (is_digit) begin
                              size_in = {27'd0, digit};
                           end else if (chr == CHAR_MINUS) begin
                              neg_in = 1'b1;
                           end else if (chr != CHAR_PLUS) begin
                              stop_in = 1'b1;
                           end
                        end else if (!cur_stop) begin
                           if (is_digit) begin
                              size_in = size_sat;
                           end else begin
                              stop_in = 1'b1;
                           end
                        end
                     end
                  end
                  PH_PAYLOAD: begin
                     rem_in = rem_dec;
                     emit   = 1'b1;
                     result = '{out_kind: KIND_PAYLOAD, out_char: chr,
                                out_last: (rem_dec == 31'd0)};
                     if (rem_dec == 31'd0) begin
                        phase_in = PH_IDLE;
                     end
                  end
                  default: begin
                     phase_in = cur_phase;
                  end
               endcase
            end
         end
      end
   end

   assign rsp_valid_in = (rsp_valid_ff && !rsp_ready) || (accept && emit);
   assign rsp_data_in  = (accept && emit) ? result : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_SKIP;
         pos_ff          <= '0;
         bit_ff          <= '0;
         acc_ff          <= '0;
         fc_ff           <= '0;
         size_ff         <= '0;
         neg_ff          <= 1'b0;
         stop_ff         <= 1'b0;
         rem_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         pos_ff          <= pos_in;
         bit_ff          <= bit_in;
         acc_ff          <= acc_in;
         fc_ff           <= fc_in;
         size_ff         <= size_in;
         neg_ff          <= neg_in;
         stop_ff         <= stop_in;
         rem_ff          <= rem_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_offset_ff <= PIXEL_OFFSET_RESET;
         magic_word_ff   <= MAGIC_WORD_RESET;
         magic_length_ff <= MAGIC_LENGTH_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_PIXEL_OFFSET: pixel_offset_ff <= csr_wdata[23:0];
            CSR_MAGIC_WORD:   magic_word_ff   <= csr_wdata;
            CSR_MAGIC_LENGTH: magic_length_ff <= csr_wdata[3:0];
            default: begin
               magic_length_ff <= magic_length_ff;
            end
         endcase
      end
   end

endmodule

// File: rtl/core/lsbse_checker.sv
// port checker for the extractor, bound to the top level
`timescale 1ns / 1ps
`include "lsb_stego_payload_extractor_top_macros.svh"

module lsbse_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input lsbse_pkg::rsp_type rsp_data
);
   import lsbse_pkg::*;

   // a stalled result stays valid and unchanged
   `LSBSE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // an empty result register never blocks the input side
   `LSBSE_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)

   // only character kinds carry a character
   `LSBSE_ASSERT_NOW(a_char_zero, clock, reset, rsp_valid && rsp_data.out_kind != KIND_EXT_CHAR && rsp_data.out_kind != KIND_PAYLOAD, rsp_data.out_char == 8'd0)

   // terminal kinds always close the file
   `LSBSE_ASSERT_NOW(a_terminal_last, clock, reset, rsp_valid && (rsp_data.out_kind == KIND_NO_MAGIC || rsp_data.out_kind == KIND_TOO_LONG || rsp_data.out_kind == KIND_EMPTY_DONE), rsp_data.out_last)

   // extension results never close the file
   `LSBSE_ASSERT_NOW(a_ext_not_last, clock, reset, rsp_valid && (rsp_data.out_kind == KIND_EXT_CHAR || rsp_data.out_kind == KIND_EXT_END), !rsp_data.out_last)

endmodule

bind lsb_stego_payload_extractor_top lsbse_checker u_lsbse_checker (.*);

// File: tb/lsbse_result_checker.sv
// result checker for the lsb stego payload extractor: predicts and compares every result
`timescale 1ns / 1ps

module lsbse_result_checker
   import lsbse_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  req_type                req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rsp_type                rsp_data,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   run_done,
   output int                     error_count,
   output int                     outstanding
);

   logic [23:0] cfg_offset;
   logic [63:0] cfg_magic;
   logic [3:0]  cfg_mlen;

   phase_type   dec_phase;
   logic [23:0] hdr_count;
   logic [2:0]  bit_pos;
   logic [7:0]  char_bits;
   logic [3:0]  field_len;
   logic [30:0] size_acc;
   logic        size_neg;
   logic        size_halted;
   logic [30:0] payload_left;

   rsp_type     expected_results[$];
   int          mismatches = 0;
   bit          leftover_noted = 1'b0;

   function automatic void clear_decoder();
      dec_phase    = PH_SKIP;
      hdr_count    = '0;
      bit_pos      = '0;
      char_bits    = '0;
      field_len    = '0;
      size_acc     = '0;
      size_neg     = 1'b0;
      size_halted  = 1'b0;
      payload_left = '0;
   endfunction

   function automatic void queue_result(input out_kind_type kind, input logic [7:0] ch,
                                        input logic last);
      rsp_type r;
      r.out_kind = kind;
      r.out_char = ch;
      r.out_last = last;
      expected_results.push_back(r);
   endfunction

   // one image byte through the decoder, queueing whatever result it gives
   task automatic extract_from_byte(input req_type r);
      logic [7:0]  ch;
      logic [3:0]  magic_chars;
      logic [30:0] size_now;
      logic [63:0] grown;
      logic        digit;
      if (r.start_of_file) clear_decoder();
      if (dec_phase == PH_IDLE) return;
      if (dec_phase == PH_SKIP) begin
         if (hdr_count < cfg_offset) begin
            hdr_count++;
            return;
         end
         dec_phase = PH_MAGIC;
         field_len = '0;
         bit_pos   = '0;
         char_bits = '0;
      end
      char_bits[bit_pos] = r.image_byte[0];
      if (bit_pos != 3'd7) begin
         bit_pos++;
         return;
      end
      ch        = char_bits;
      bit_pos   = '0;
      char_bits = '0;
      case (dec_phase)
         PH_MAGIC: begin
            // zero still compares one character, anything past the maximum is clipped
            magic_chars = (cfg_mlen == 0) ? 4'd1 :
                          (cfg_mlen > MAX_MAGIC_CHARS) ? MAX_MAGIC_CHARS : cfg_mlen;
            if (ch != cfg_magic[{field_len[2:0], 3'b000} +: 8]) begin
               dec_phase = PH_IDLE;
               queue_result(KIND_NO_MAGIC, '0, 1'b1);
            end else begin
               field_len++;
               if (field_len >= magic_chars) begin
                  field_len = '0;
                  dec_phase = PH_EXT;
               end
            end
         end
         PH_EXT: begin
            if (ch == CHAR_STAR) begin
               field_len = '0;
               dec_phase = PH_SIZE;
               queue_result(KIND_EXT_END, '0, 1'b0);
            end else if (field_len >= MAX_EXT_CHARS) begin
               dec_phase = PH_IDLE;
               queue_result(KIND_TOO_LONG, '0, 1'b1);
            end else begin
               field_len++;
               queue_result(KIND_EXT_CHAR, ch, 1'b0);
            end
         end
         PH_SIZE: begin
            if (ch == CHAR_STAR) begin
               size_now  = size_neg ? '0 : size_acc;
               field_len = '0;
               if (size_now == 0) begin
                  dec_phase = PH_IDLE;
                  queue_result(KIND_EMPTY_DONE, '0, 1'b1);
               end else begin
                  payload_left = size_now;
                  dec_phase    = PH_PAYLOAD;
               end
            end else if (field_len >= MAX_SIZE_CHARS) begin
               dec_phase = PH_IDLE;
               queue_result(KIND_TOO_LONG, '0, 1'b1);
            end else begin
               digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
               if (field_len == 0) begin
                  // leading sign allowed; any other non-digit freezes the size at zero
                  if (digit) size_acc = 31'(ch - CHAR_ZERO);
                  else if (ch == CHAR_MINUS) size_neg = 1'b1;
                  else if (ch != CHAR_PLUS) size_halted = 1'b1;
               end else if (!size_halted) begin
                  if (digit) begin
                     grown    = 64'(size_acc) * 64'd10 + 64'(ch - CHAR_ZERO);
                     size_acc = (grown > 64'(SIZE_MAX)) ? SIZE_MAX : grown[30:0];
                  end else begin
                     size_halted = 1'b1;
                  end
               end
               field_len++;
            end
         end
         PH_PAYLOAD: begin
            payload_left--;
            queue_result(KIND_PAYLOAD, ch, payload_left == 0);
            if (payload_left == 0) dec_phase = PH_IDLE;
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         cfg_offset = PIXEL_OFFSET_RESET;
         cfg_magic  = MAGIC_WORD_RESET;
         cfg_mlen   = MAGIC_LENGTH_RESET;
         clear_decoder();
         expected_results.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_PIXEL_OFFSET: cfg_offset = csr_wdata[23:0];
               CSR_MAGIC_WORD:   cfg_magic  = csr_wdata;
               CSR_MAGIC_LENGTH: cfg_mlen   = csr_wdata[3:0];
               default: ;
            endcase
         end
         // retire the result first so a request on the same edge cannot satisfy it
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result: kind %0d char %02h last %0d", $time,
                        rsp_data.out_kind, rsp_data.out_char, rsp_data.out_last);
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.out_kind !== want.out_kind || rsp_data.out_char !== want.out_char ||
                   rsp_data.out_last !== want.out_last) begin
                  mismatches++;
                  $display("%0t: mismatch: expected kind %0d char %02h last %0d, got kind %0d char %02h last %0d",
                           $time, want.out_kind, want.out_char, want.out_last,
                           rsp_data.out_kind, rsp_data.out_char, rsp_data.out_last);
               end
            end
         end
         if (req_valid && req_ready) extract_from_byte(req_data);
         if (run_done && !leftover_noted) begin
            leftover_noted = 1'b1;
            if (expected_results.size() != 0) begin
               mismatches += expected_results.size();
               $display("%0t: %0d expected results never arrived", $time,
                        expected_results.size());
            end
         end
      end
      error_count <= mismatches;
      outstanding <= expected_results.size();
   end

endmodule

// File: tb/lsb_stego_payload_extractor_top_tb.sv
// testbench top for the lsb stego payload extractor: stimulus, flow control and verdict
`timescale 1ns / 1ps

module lsb_stego_payload_extractor_top_tb;
   import lsbse_pkg::*;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   run_done = 1'b0;
   int                     error_count;
   int                     outstanding;

   // register values as last written, used to build well-formed files
   logic [23:0] tb_offset = PIXEL_OFFSET_RESET;
   logic [63:0] tb_magic  = MAGIC_WORD_RESET;
   logic [3:0]  tb_mlen   = MAGIC_LENGTH_RESET;

   req_type     file_bytes[$];
   bit          calm = 1'b0;
   bit          hold_rsp = 1'b0;

   lsb_stego_payload_extractor_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   lsbse_result_checker result_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .run_done     (run_done),
      .error_count  (error_count),
      .outstanding  (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin : watchdog
      #400us;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // receiver: random back-pressure plus one long hold-off on request
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (hold_rsp) begin
            hold_rsp  = 1'b0;
            hold_left = 299;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 24);
         end
      end
   end

   function automatic void put_byte(input logic [7:0] b);
      req_type r;
      r.image_byte    = b;
      r.start_of_file = (file_bytes.size() == 0);
      file_bytes.push_back(r);
   endfunction

   // one hidden character spread over the lsbs of eight bytes, lsb first
   function automatic void put_char(input logic [7:0] ch);
      logic [7:0] b;
      for (int i = 0; i < BITS_PER_CHAR; i++) begin
         b    = 8'($urandom);
         b[0] = ch[i];
         put_byte(b);
      end
   endfunction

   function automatic void put_text(input string s);
      for (int i = 0; i < s.len(); i++) put_char(s[i]);
   endfunction

   function automatic void put_payload(input int count);
      repeat (count) put_char(($urandom_range(9) == 0) ? 8'h00 : 8'($urandom));
   endfunction

   function automatic void start_file();
      file_bytes.delete();
      repeat (tb_offset) put_byte(8'($urandom));
   endfunction

   // bad_at picks a magic character to corrupt, -1 for none
   function automatic void put_magic(input int bad_at);
      int         chars;
      logic [7:0] ch;
      chars = (tb_mlen == 0) ? 1 : (tb_mlen > MAX_MAGIC_CHARS) ? MAX_MAGIC_CHARS : tb_mlen;
      for (int i = 0; i < chars; i++) begin
         ch = tb_magic[8*i +: 8];
         if (i == bad_at) ch = ~ch;
         put_char(ch);
      end
   endfunction

   // random idle gaps before about one request in eight, except while calm is set
   task automatic send_file();
      foreach (file_bytes[i]) begin
         if (!calm && $urandom_range(99) < 12) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data  <= file_bytes[i];
         do @(posedge clock); while (!req_ready);
      end
   endtask

   // stop offering and let every expected result drain before touching registers
   task automatic drain_and_pause();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_regs(input logic [23:0] offset, input logic [63:0] word,
                               input logic [3:0] len);
      logic [63:0] junk;
      junk      = {$urandom, $urandom};
      tb_offset = offset;
      tb_magic  = word;
      tb_mlen   = len;
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_PIXEL_OFFSET;
      csr_wdata    <= {junk[63:24], offset};
      @(posedge clock);
      csr_index    <= CSR_MAGIC_WORD;
      csr_wdata    <= word;
      @(posedge clock);
      csr_index    <= CSR_MAGIC_LENGTH;
      csr_wdata    <= {junk[63:4], len};
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   initial begin : stimulus
      int          file_idx;
      int          random_bytes;
      int          ext_len;
      int          n;
      int          form;
      int          cut;
      logic [23:0] off;
      logic [7:0]  ch;
      string       num;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // register defaults: 54 header bytes and two nul magic characters
      start_file(); put_magic(-1); put_text("ab*3*");
      put_char(8'h00); put_char(8'hFF); put_char(CHAR_STAR);
      send_file();

      drain_and_pause();
      program_regs(24'd0, '1, 4'd15);
      start_file(); put_magic(-1); put_text("abcdefgh*-5*z"); send_file();
      start_file(); put_magic(-1); put_text("abcdefghi"); send_file();
      start_file(); put_magic(-1); put_text("*12345678901"); send_file();
      start_file(); put_magic(-1); put_text("*0000000003*"); put_payload(3); send_file();
      start_file(); put_magic(-1); put_text("*x9*"); send_file();
      start_file(); put_magic(-1); put_text("*+2*"); put_payload(2); send_file();
      start_file(); put_magic(-1); put_text("*12a7*"); put_payload(12); send_file();
      start_file(); put_magic(-1); put_text("**"); send_file();
      // saturated size, file cut short after a few payload bytes
      start_file(); put_magic(-1); put_text("*9999999999*"); put_payload(4); send_file();

      drain_and_pause();
      program_regs('1, {$urandom, $urandom}, 4'd0);
      file_bytes.delete();
      repeat (40) put_byte(8'($urandom));
      send_file();

      drain_and_pause();
      program_regs(24'd3, {$urandom, $urandom}, 4'd0);
      start_file(); put_magic(0); put_text("ab"); send_file();
      start_file(); put_magic(-1); put_text("*0*"); send_file();

      file_idx     = 0;
      random_bytes = 0;
      while (random_bytes < 2000) begin
         if (file_idx % 5 == 0) begin
            drain_and_pause();
            case ($urandom_range(3))
               0:       off = '0;
               1:       off = PIXEL_OFFSET_RESET;
               default: off = 24'($urandom_range(1, 24));
            endcase
            program_regs(off, {$urandom, $urandom}, 4'($urandom_range(15)));
         end
         calm = (file_idx >= 8 && file_idx < 13);
         start_file();
         if (file_idx == 3) begin
            // long payload while the receiver holds off, so the block backs up
            hold_rsp = 1'b1;
            put_magic(-1);
            put_text("*40*");
            put_payload(40);
         end else if ($urandom_range(99) < 10) begin
            repeat ($urandom_range(2, 12)) put_char(8'($urandom));
         end else begin
            put_magic(($urandom_range(99) < 10) ? int'($urandom_range(7)) : -1);
            ext_len = ($urandom_range(99) < 8) ? 9 : $urandom_range(0, 8);
            repeat (ext_len) begin
               do ch = 8'($urandom); while (ch == CHAR_STAR);
               put_char(ch);
            end
            put_char(CHAR_STAR);
            n    = ($urandom_range(99) < 15) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            num  = $sformatf("%0d", n);
            form = $urandom_range(99);
            if (form < 40) begin
               put_text(num);
            end else if (form < 50) begin
               put_text({"+", num});
            end else if (form < 60) begin
               put_text({"-", num});
               n = 0;
            end else if (form < 70) begin
               put_text(num);
               put_char(8'h61 + 8'($urandom_range(25)));
               put_text($sformatf("%0d", $urandom_range(999)));
            end else if (form < 78) begin
               put_char(8'h61 + 8'($urandom_range(25)));
               put_text(num);
               n = 0;
            end else if (form < 85) begin
               n = 0;
            end else if (form < 92) begin
               put_text({"000", num});
            end else begin
               repeat (11) put_char(CHAR_ZERO + 8'($urandom_range(9)));
               n = 0;
            end
            put_char(CHAR_STAR);
            put_payload(n);
            // trailing bytes after the end are ignored
            if ($urandom_range(99) < 20) repeat ($urandom_range(1, 3)) put_char(8'($urandom));
            if ($urandom_range(99) < 8) begin
               cut = $urandom_range(1, file_bytes.size());
               while (file_bytes.size() > cut) void'(file_bytes.pop_back());
            end
         end
         random_bytes += file_bytes.size();
         send_file();
         file_idx++;
      end

      drain_and_pause();
      run_done <= 1'b1;
      repeat (2) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/lsbse_pkg.sv
rtl/core/lsb_stego_payload_extractor_top.sv
rtl/core/lsbse_checker.sv
tb/lsbse_result_checker.sv
tb/lsb_stego_payload_extractor_top_tb.sv
